// ===== sv/wsd_pkg.sv =====
// wsd_pkg: shared types and codes for the WAV stream decoder.
// Used by every module of the block but wsd_fifo; depends on nothing.
`default_nettype none
package wsd_pkg;

  localparam int OUT_WIDTH_DEF = 32;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [1:0] MODE_BYTE = 2'd0;
  localparam logic [1:0] MODE_END = 2'd1;
  localparam logic [1:0] MODE_RESTART = 2'd2;
  localparam logic [1:0] MODE_NONE = 2'd3;

  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_FORMAT = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;
  localparam logic [1:0] KIND_FINISH = 2'd3;

  localparam logic [2:0] ERR_HEADER = 3'd0;
  localparam logic [2:0] ERR_FMT = 3'd1;
  localparam logic [2:0] ERR_TAG = 3'd2;
  localparam logic [2:0] ERR_LAYOUT = 3'd3;
  localparam logic [2:0] ERR_ORDER = 3'd4;
  localparam logic [2:0] ERR_MISSING = 3'd5;
  localparam logic [2:0] ERR_PARTIAL = 3'd6;

  localparam logic [15:0] FMT_PCM = 16'h0001;
  localparam logic [15:0] FMT_FLOAT = 16'h0003;
  localparam logic [15:0] FMT_EXT = 16'hFFFE;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] byte_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic signed [31:0] sample_value;
    logic [31:0] sample_rate;
    logic [6:0] sample_bits;
    logic [5:0] valid_bits;
    logic is_float;
    logic [2:0] error_code;
  } out_item_t;

  // front to back: a sample carries its raw word and the bits, valid bits and float flag in force
  typedef struct packed {
    logic [1:0] kind;
    logic [63:0] word;
    logic [31:0] rate;
    logic [6:0] bits;
    logic [5:0] valid;
    logic is_float;
    logic [2:0] err;
  } cmd_t;

  localparam int CMD_W = $bits(cmd_t);
  localparam int OUT_W = $bits(out_item_t);

endpackage
`default_nettype wire

// ===== sv/wsd_fifo.sv =====
// wsd_fifo: small register queue between the parts of the decoder.
// Standalone; no package needed.
`default_nettype none
module wsd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input wire logic clk,
  input wire logic rst,
  input wire logic wr_en,
  input wire logic [WIDTH-1:0] wr_data,
  input wire logic rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic full,
  output logic empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0] count;
  logic do_wr;
  logic do_rd;

  assign full = (count == (AW+1)'(DEPTH));
  assign empty = (count == '0);
  assign do_wr = wr_en && !full;
  assign do_rd = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + (AW+1)'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - (AW+1)'(1);
      end
    end
  end
endmodule
`default_nettype wire

// ===== sv/wsd_front.sv =====
// wsd_front: byte-serial RIFF/WAVE parser, one byte per transfer.
// Depends on wsd_pkg; emits at most one command per byte.
`default_nettype none
module wsd_front (
  input wire logic clk,
  input wire logic rst,
  input wire logic accept,
  input wire wsd_pkg::in_item_t request,
  output logic cmd_valid,
  output wsd_pkg::cmd_t cmd
);
  import wsd_pkg::*;

  typedef enum logic [10:0] {
    PH_RIFF  = 11'b00000000001,
    PH_RSIZE = 11'b00000000010,
    PH_WAVE  = 11'b00000000100,
    PH_CTAG  = 11'b00000001000,
    PH_CSIZE = 11'b00000010000,
    PH_FMT   = 11'b00000100000,
    PH_SKIP  = 11'b00001000000,
    PH_PAD   = 11'b00010000000,
    PH_DATA  = 11'b00100000000,
    PH_DONE  = 11'b01000000000,
    PH_HALT  = 11'b10000000000
  } phase_t;

  localparam logic [31:0] TAG_RIFF = 32'h46464952;
  localparam logic [31:0] TAG_WAVE = 32'h45564157;
  localparam logic [31:0] TAG_FMT = 32'h20746D66;
  localparam logic [31:0] TAG_DATA = 32'h61746164;

  phase_t phase, phase_next;
  logic [31:0] fbc, fbc_next;
  logic [31:0] clen, clen_next;
  logic [31:0] tag, tag_next;
  logic [15:0] ftag, ftag_next;
  logic [15:0] chans, chans_next;
  logic [31:0] rate, rate_next;
  logic [15:0] bits, bits_next;
  logic [15:0] vbits, vbits_next;
  logic [15:0] extlen, extlen_next;
  logic [31:0] subfmt, subfmt_next;
  logic fmt_seen, fmt_seen_next;
  logic [63:0] asm_word, asm_word_next;
  logic [2:0] sidx, sidx_next;

  logic emit;
  cmd_t res;
  logic [7:0] b;
  logic [63:0] word_full;
  logic [15:0] ext;
  logic fmt_ok;
  logic is_flt;
  logic [5:0] vclamp;

  assign b = request.byte_value;
  assign is_flt = (ftag == FMT_FLOAT) || (ftag == FMT_EXT && subfmt == 32'd3);
  assign vclamp = (vbits == 16'd0) ? 6'd1 : (vbits > 16'd32) ? 6'd32 : vbits[5:0];
  assign word_full = asm_word | ({56'd0, b} << {sidx, 3'b000});

  function automatic logic layout_ok(input logic [15:0] ch, input logic [31:0] rt,
                                     input logic [15:0] bt, input logic flt);
    logic ok;
    ok = 1'b0;
    if (ch == 16'd1 && rt != 32'd0) begin
      if (flt) begin
        ok = (bt == 16'd32) || (bt == 16'd64);
      end else begin
        ok = (bt == 16'd8) || (bt == 16'd16) || (bt == 16'd24) || (bt == 16'd32);
      end
    end
    return ok;
  endfunction

  always_comb begin
    phase_next = phase;
    fbc_next = fbc;
    clen_next = clen;
    tag_next = tag;
    ftag_next = ftag;
    chans_next = chans;
    rate_next = rate;
    bits_next = bits;
    vbits_next = vbits;
    extlen_next = extlen;
    subfmt_next = subfmt;
    fmt_seen_next = fmt_seen;
    asm_word_next = asm_word;
    sidx_next = sidx;
    emit = 1'b0;
    res = '0;
    ext = '0;
    fmt_ok = 1'b0;
    case (request.mode)
      MODE_RESTART: begin
        phase_next = PH_RIFF;
        fbc_next = '0;
        clen_next = '0;
        tag_next = '0;
        ftag_next = '0;
        chans_next = '0;
        rate_next = '0;
        bits_next = '0;
        vbits_next = '0;
        extlen_next = '0;
        subfmt_next = '0;
        fmt_seen_next = 1'b0;
        asm_word_next = '0;
        sidx_next = '0;
      end
      MODE_END: begin
        if (phase != PH_HALT) begin
          emit = 1'b1;
          phase_next = PH_HALT;
          res.kind = KIND_ERROR;
          if (phase == PH_RIFF || phase == PH_RSIZE || phase == PH_WAVE) begin
            res.err = ERR_HEADER;
          end else if (phase == PH_FMT) begin
            res.err = ERR_FMT;
          end else if (phase == PH_DONE) begin
            if (sidx != 3'd0) begin
              res.err = ERR_PARTIAL;
            end else begin
              res.kind = KIND_FINISH;
            end
          end else begin
            res.err = ERR_MISSING;
          end
        end
      end
      MODE_BYTE: begin
        case (phase)
          PH_RIFF, PH_RSIZE, PH_WAVE, PH_CTAG, PH_CSIZE: begin
            if (phase == PH_RSIZE || phase == PH_CSIZE) begin
              clen_next = {b, clen[31:8]};
            end else begin
              tag_next = {b, tag[31:8]};
            end
            if (fbc < 32'd3) begin
              fbc_next = fbc + 32'd1;
            end else begin
              fbc_next = '0;
              case (phase)
                PH_RIFF: begin
                  if (tag_next != TAG_RIFF) begin
                    emit = 1'b1;
                    res.kind = KIND_ERROR;
                    res.err = ERR_HEADER;
                    phase_next = PH_HALT;
                  end else begin
                    phase_next = PH_RSIZE;
                  end
                end
                PH_RSIZE: phase_next = PH_WAVE;
                PH_WAVE: begin
                  if (tag_next != TAG_WAVE) begin
                    emit = 1'b1;
                    res.kind = KIND_ERROR;
                    res.err = ERR_HEADER;
                    phase_next = PH_HALT;
                  end else begin
                    phase_next = PH_CTAG;
                  end
                end
                PH_CTAG: phase_next = PH_CSIZE;
                default: begin
                  if (tag == TAG_FMT) begin
                    if (clen_next < 32'd16) begin
                      emit = 1'b1;
                      res.kind = KIND_ERROR;
                      res.err = ERR_FMT;
                      phase_next = PH_HALT;
                    end else begin
                      vbits_next = '0;
                      extlen_next = '0;
                      subfmt_next = '0;
                      phase_next = PH_FMT;
                    end
                  end else if (tag == TAG_DATA) begin
                    emit = 1'b1;
                    if (!fmt_seen) begin
                      res.kind = KIND_ERROR;
                      res.err = ERR_ORDER;
                      phase_next = PH_HALT;
                    end else if (!layout_ok(chans, rate, bits, is_flt)) begin
                      res.kind = KIND_ERROR;
                      res.err = ERR_LAYOUT;
                      phase_next = PH_HALT;
                    end else begin
                      asm_word_next = '0;
                      sidx_next = '0;
                      phase_next = (clen_next == 32'd0) ? PH_DONE : PH_DATA;
                      res.kind = KIND_FORMAT;
                      res.rate = rate;
                      res.bits = bits[6:0];
                      res.valid = vclamp;
                      res.is_float = is_flt;
                    end
                  end else if (clen_next == 32'd0) begin
                    phase_next = PH_CTAG;
                  end else begin
                    phase_next = PH_SKIP;
                  end
                end
              endcase
            end
          end
          PH_FMT: begin
            if (fbc < 32'd2) begin
              if (fbc[0]) ftag_next[15:8] = b;
              else ftag_next[7:0] = b;
            end else if (fbc < 32'd4) begin
              if (fbc[0]) chans_next[15:8] = b;
              else chans_next[7:0] = b;
            end else if (fbc < 32'd8) begin
              case (fbc[1:0])
                2'd0: rate_next[7:0] = b;
                2'd1: rate_next[15:8] = b;
                2'd2: rate_next[23:16] = b;
                default: rate_next[31:24] = b;
              endcase
            end else if (fbc == 32'd14) begin
              bits_next[7:0] = b;
            end else if (fbc == 32'd15) begin
              bits_next[15:8] = b;
            end else if (fbc == 32'd16) begin
              extlen_next[7:0] = b;
            end else if (fbc == 32'd17) begin
              extlen_next[15:8] = b;
            end else if (fbc >= 32'd18 && ftag == FMT_EXT && extlen >= 16'd22 &&
                         clen >= 32'd40) begin
              if (fbc < 32'd20) begin
                if (fbc[0]) vbits_next[15:8] = b;
                else vbits_next[7:0] = b;
              end else if (fbc >= 32'd24 && fbc < 32'd28) begin
                case (fbc[1:0])
                  2'd0: subfmt_next[7:0] = b;
                  2'd1: subfmt_next[15:8] = b;
                  2'd2: subfmt_next[23:16] = b;
                  default: subfmt_next[31:24] = b;
                endcase
              end
            end
            if (fbc + 32'd1 == clen) begin
              ext = vbits_next;
              vbits_next = bits_next;
              if (ftag_next == FMT_PCM || ftag_next == FMT_FLOAT) begin
                fmt_ok = 1'b1;
              end else if (ftag_next == FMT_EXT) begin
                if (ext != 16'd0) vbits_next = ext;
                fmt_ok = (subfmt_next == 32'd1) || (subfmt_next == 32'd3);
              end
              if (!fmt_ok) begin
                emit = 1'b1;
                res.kind = KIND_ERROR;
                res.err = ERR_TAG;
                phase_next = PH_HALT;
              end else begin
                fmt_seen_next = 1'b1;
                fbc_next = '0;
                phase_next = clen[0] ? PH_PAD : PH_CTAG;
              end
            end else begin
              fbc_next = fbc + 32'd1;
            end
          end
          PH_SKIP: begin
            if (fbc + 32'd1 == clen) begin
              fbc_next = '0;
              phase_next = clen[0] ? PH_PAD : PH_CTAG;
            end else begin
              fbc_next = fbc + 32'd1;
            end
          end
          PH_PAD: begin
            fbc_next = '0;
            phase_next = PH_CTAG;
          end
          PH_DATA: begin
            if ({13'd0, sidx} + 16'd1 >= {3'd0, bits[15:3]}) begin
              emit = 1'b1;
              res.kind = KIND_SAMPLE;
              res.word = word_full;
              res.bits = bits[6:0];
              res.valid = vclamp;
              res.is_float = is_flt;
              asm_word_next = '0;
              sidx_next = '0;
            end else begin
              asm_word_next = word_full;
              sidx_next = sidx + 3'd1;
            end
            if (fbc + 32'd1 == clen) begin
              phase_next = PH_DONE;
            end else begin
              fbc_next = fbc + 32'd1;
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  assign cmd_valid = emit;
  assign cmd = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_RIFF;
      fbc <= '0;
      clen <= '0;
      tag <= '0;
      ftag <= '0;
      chans <= '0;
      rate <= '0;
      bits <= '0;
      vbits <= '0;
      extlen <= '0;
      subfmt <= '0;
      fmt_seen <= 1'b0;
      asm_word <= '0;
      sidx <= '0;
    end else if (accept) begin
      phase <= phase_next;
      fbc <= fbc_next;
      clen <= clen_next;
      tag <= tag_next;
      ftag <= ftag_next;
      chans <= chans_next;
      rate <= rate_next;
      bits <= bits_next;
      vbits <= vbits_next;
      extlen <= extlen_next;
      subfmt <= subfmt_next;
      fmt_seen <= fmt_seen_next;
      asm_word <= asm_word_next;
      sidx <= sidx_next;
    end
  end
endmodule
`default_nettype wire

// ===== sv/wsd_back.sv =====
// wsd_back: sample conversion to Q1.31 in two steps, unpack then shift/saturate.
// Depends on wsd_pkg; reads the command queue, writes the result queue.
`default_nettype none
module wsd_back #(
  parameter int OUT_WIDTH = wsd_pkg::OUT_WIDTH_DEF
) (
  input wire logic clk,
  input wire logic rst,
  input wire logic cmd_empty,
  input wire wsd_pkg::cmd_t cmd_head,
  output logic cmd_pop,
  input wire logic out_full,
  output logic out_push,
  output wsd_pkg::out_item_t out_data
);
  import wsd_pkg::*;

  localparam int DROP = 32 - OUT_WIDTH;
  localparam logic [31:0] KEEP_MASK = ~32'd0 << DROP;

  typedef struct packed {
    out_item_t pass;
    logic direct;
    logic [31:0] q;
    logic sat;
    logic neg;
    logic [52:0] mant;
    logic signed [12:0] sh;
  } stage_t;

  stage_t st, st_next;
  logic st_valid;
  logic advance;

  logic [10:0] e;
  logic [10:0] emax;
  logic [51:0] frac;
  logic [10:0] eff;
  logic [5:0] pcm_sh;

  always_comb begin
    st_next = '0;
    st_next.pass.kind = cmd_head.kind;
    st_next.pass.sample_rate = cmd_head.rate;
    st_next.pass.sample_bits = cmd_head.bits;
    st_next.pass.valid_bits = cmd_head.valid;
    st_next.pass.is_float = cmd_head.is_float;
    st_next.pass.error_code = cmd_head.err;
    st_next.direct = 1'b1;
    e = '0;
    emax = '0;
    frac = '0;
    eff = '0;
    pcm_sh = 6'd32 - cmd_head.valid;
    if (cmd_head.kind == KIND_SAMPLE) begin
      st_next.pass = '0;
      if (cmd_head.is_float) begin
        if (cmd_head.bits == 7'd32) begin
          e = {3'd0, cmd_head.word[30:23]};
          emax = 11'd255;
          frac = {cmd_head.word[22:0], 29'd0};
          st_next.neg = cmd_head.word[31];
        end else begin
          e = cmd_head.word[62:52];
          emax = 11'h7FF;
          frac = cmd_head.word[51:0];
          st_next.neg = cmd_head.word[63];
        end
        if (e == emax) begin
          if (frac != '0) begin
            st_next.q = '0;
          end else begin
            st_next.direct = 1'b0;
            st_next.sat = 1'b1;
          end
        end else begin
          st_next.direct = 1'b0;
          eff = (e == '0) ? 11'd1 : e;
          if (cmd_head.bits == 7'd32) begin
            st_next.mant = {29'd0, (e != '0), cmd_head.word[22:0]};
            st_next.sh = $signed({2'b00, eff}) - 13'sd119;
          end else begin
            st_next.mant = {(e != '0), frac};
            st_next.sh = $signed({2'b00, eff}) - 13'sd1044;
          end
        end
      end else begin
        case (cmd_head.bits)
          7'd8: st_next.q = {cmd_head.word[7:0] ^ 8'h80, 24'd0};
          7'd16: st_next.q = {cmd_head.word[15:0], 16'd0};
          7'd24: st_next.q = {cmd_head.word[23:0], 8'd0};
          default: st_next.q = cmd_head.word[31:0] & (~32'd0 << pcm_sh[4:0]);
        endcase
      end
    end
  end

  logic [31:0] lim;
  logic [84:0] wide;
  logic [12:0] rsh;
  logic [31:0] mag;
  logic [31:0] qv;

  always_comb begin
    lim = st.neg ? 32'h80000000 : 32'h7FFFFFFF;
    rsh = 13'd0 - st.sh;
    wide = '0;
    if (!st.sh[12]) begin
      wide = {32'd0, st.mant} << st.sh[4:0];
    end else if (rsh < 13'd64) begin
      wide = {32'd0, st.mant >> rsh[5:0]};
    end
    if (st.sat) begin
      mag = lim;
    end else if (!st.sh[12] && st.sh >= 13'sd32) begin
      mag = (st.mant != '0) ? lim : 32'd0;
    end else if (wide > {53'd0, lim}) begin
      mag = lim;
    end else begin
      mag = wide[31:0];
    end
    qv = st.direct ? st.q : (st.neg ? 32'd0 - mag : mag);
    out_data = st.pass;
    if (st.pass.kind == KIND_SAMPLE) begin
      out_data.sample_value = $signed(qv & KEEP_MASK);
    end
  end

  assign advance = !st_valid || !out_full;
  assign cmd_pop = advance && !cmd_empty;
  assign out_push = st_valid && !out_full;

  always_ff @(posedge clk) begin
    if (advance) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= 1'b0;
    end else if (advance) begin
      st_valid <= !cmd_empty;
    end
  end
endmodule
`default_nettype wire

// ===== sv/wav_stream_decoder.sv =====
// wav_stream_decoder: top level, parser front, command queue, converter back, result queue.
// Depends on wsd_pkg, wsd_front, wsd_back and wsd_fifo.
// One file byte is taken per clock unless full is high. Each byte produces at most one
// result: a sample in Q1.31 (low 32-OUT_WIDTH bits cleared), a format report when the
// data chunk starts, a numbered error, or a finish on end of stream. A result passes
// through the command queue, the unpack register and the result queue before it shows
// on the result ports; both queues hold QUEUE_DEPTH entries, so full rises only when
// results are not popped. After an error or finish the block ignores bytes until a
// restart item.
`default_nettype none
module wav_stream_decoder #(
  parameter int OUT_WIDTH = wsd_pkg::OUT_WIDTH_DEF,
  parameter int QUEUE_DEPTH = wsd_pkg::QUEUE_DEPTH_DEF
) (
  input wire logic clk,
  input wire logic rst,
  input wire logic push,
  output logic full,
  input wire wsd_pkg::in_item_t request,
  output logic empty,
  input wire logic pop,
  output wsd_pkg::out_item_t result
);
  import wsd_pkg::*;

  logic accept;
  logic cmd_valid;
  cmd_t cmd;
  cmd_t cmd_head;
  logic cmd_empty;
  logic cmd_pop;
  logic out_full;
  logic out_push;
  out_item_t out_data;

  assign accept = push && !full;

  wsd_front u_front (
    .clk(clk),
    .rst(rst),
    .accept(accept),
    .request(request),
    .cmd_valid(cmd_valid),
    .cmd(cmd)
  );

  wsd_fifo #(.WIDTH(CMD_W), .DEPTH(QUEUE_DEPTH)) u_cmd_q (
    .clk(clk),
    .rst(rst),
    .wr_en(accept && cmd_valid),
    .wr_data(cmd),
    .rd_en(cmd_pop),
    .rd_data(cmd_head),
    .full(full),
    .empty(cmd_empty)
  );

  wsd_back #(.OUT_WIDTH(OUT_WIDTH)) u_back (
    .clk(clk),
    .rst(rst),
    .cmd_empty(cmd_empty),
    .cmd_head(cmd_head),
    .cmd_pop(cmd_pop),
    .out_full(out_full),
    .out_push(out_push),
    .out_data(out_data)
  );

  wsd_fifo #(.WIDTH(OUT_W), .DEPTH(QUEUE_DEPTH)) u_out_q (
    .clk(clk),
    .rst(rst),
    .wr_en(out_push),
    .wr_data(out_data),
    .rd_en(pop),
    .rd_data(result),
    .full(out_full),
    .empty(empty)
  );
endmodule
`default_nettype wire

// ===== sv/wsd_checker.sv =====
// wsd_checker: port-level checks for wav_stream_decoder, with its bind.
// Depends on wsd_pkg and the top level's ports.
`default_nettype none
module wsd_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic full,
  input wire logic empty,
  input wire logic pop,
  input wire wsd_pkg::out_item_t result
);
  import wsd_pkg::*;

  a_reset_clear: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("queues not clear after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(result))
    else $error("waiting result changed");

  a_fresh_result: assert property (@(posedge clk) disable iff (rst)
    $fell(empty) |-> !$past(rst))
    else $error("result appeared straight out of reset");

  a_sample_clean: assert property (@(posedge clk) disable iff (rst)
    !empty && result.kind == KIND_SAMPLE |-> result.sample_rate == 32'd0 &&
      result.error_code == ERR_HEADER)
    else $error("sample carries format fields");
endmodule

bind wav_stream_decoder wsd_checker u_wsd_checker (
  .clk(clk),
  .rst(rst),
  .full(full),
  .empty(empty),
  .pop(pop),
  .result(result)
);
`default_nettype wire

// ===== tb/wsd_checker.sv =====
// wsd_scoreboard: watches both queue sides of wav_stream_decoder, predicts each result
// from the accepted bytes and compares it field by field. Depends on wsd_pkg.
`timescale 1ns / 1ps
module wsd_scoreboard #(
  parameter int OUT_WIDTH = 32
) (
  input logic clk,
  input logic rst,
  input logic push,
  input logic full,
  input wsd_pkg::in_item_t request,
  input logic empty,
  input logic pop,
  input wsd_pkg::out_item_t result,
  output int fails,
  output int pending,
  output int n_samples,
  output int n_formats,
  output int n_errors,
  output int n_finish
);
  import wsd_pkg::*;

  typedef enum logic [4:0] {
    P_RIFF, P_RSIZE, P_WAVE, P_CTAG, P_CSIZE, P_FMT, P_SKIP, P_PAD, P_DATA, P_DONE, P_HALT
  } phase_t;

  localparam logic [31:0] TAG_RIFF = 32'h46464952;
  localparam logic [31:0] TAG_WAVE = 32'h45564157;
  localparam logic [31:0] TAG_FMT = 32'h20746D66;
  localparam logic [31:0] TAG_DATA = 32'h61746164;

  phase_t phase;
  logic [31:0] cnt, clen, tagsh, rate, subfmt;
  logic [15:0] ftag, nch, bits, vbits, cbsize;
  logic have_fmt, have_data;
  logic [63:0] acc;
  logic [2:0] bidx;
  out_item_t exp_q[$];

  function automatic void clear_parser();
    phase = P_RIFF;
    cnt = 0; clen = 0; tagsh = 0; rate = 0; subfmt = 0;
    ftag = 0; nch = 0; bits = 0; vbits = 0; cbsize = 0;
    have_fmt = 0; have_data = 0; acc = 0; bidx = 0;
  endfunction

  function automatic logic float_fmt();
    return ftag == FMT_FLOAT || (ftag == FMT_EXT && subfmt == 32'd3);
  endfunction

  function automatic logic [31:0] clamp_vb();
    logic [31:0] v;
    v = vbits;
    if (v < 1) v = 1;
    if (v > 32) v = 32;
    return v;
  endfunction

  function automatic logic [31:0] float_q31(logic [63:0] w, int mb, int eb);
    longint unsigned emax, e, mant, lim, mag;
    int bias, eff, sh;
    logic neg;
    emax = (64'd1 << eb) - 1;
    bias = int'(emax >> 1);
    e = (w >> mb) & emax;
    mant = w & ((64'd1 << mb) - 1);
    neg = w[mb + eb];
    lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
    if (e == emax) begin
      if (mant != 0) return 32'd0;
      mag = lim;
    end else begin
      eff = 1;
      if (e != 0) begin
        mant |= 64'd1 << mb;
        eff = int'(e);
      end
      sh = eff - bias - mb + 31;
      if (mant == 0) mag = 0;
      else if (sh >= 0) begin
        if (sh >= 32 || mant > (lim >> sh)) mag = lim;
        else mag = mant << sh;
      end else begin
        mag = (-sh >= 64) ? 64'd0 : (mant >> (-sh));
        if (mag > lim) mag = lim;
      end
    end
    return neg ? 32'(64'd0 - mag) : mag[31:0];
  endfunction

  function automatic logic [31:0] convert();
    logic [63:0] q;
    if (float_fmt()) begin
      if (bits == 16'd32) q = float_q31({32'd0, acc[31:0]}, 23, 8);
      else q = float_q31(acc, 52, 11);
    end else if (bits == 16'd8) q = {acc[7:0] ^ 8'h80, 24'd0};
    else if (bits == 16'd16) q = {acc[15:0], 16'd0};
    else if (bits == 16'd24) q = {acc[23:0], 8'd0};
    else q = acc[31:0] & ~((64'd1 << (32 - clamp_vb())) - 1);
    q = q & ~((64'd1 << (32 - OUT_WIDTH)) - 1);
    return q[31:0];
  endfunction

  function automatic logic layout_good();
    if (nch != 16'd1 || rate == 0) return 0;
    if (float_fmt()) return bits == 16'd32 || bits == 16'd64;
    return bits == 16'd8 || bits == 16'd16 || bits == 16'd24 || bits == 16'd32;
  endfunction

  function automatic void end_chunk();
    cnt = 0;
    phase = clen[0] ? P_PAD : P_CTAG;
  endfunction

  function automatic logic halt(output out_item_t r, input logic [2:0] code);
    phase = P_HALT;
    r = '0;
    r.kind = KIND_ERROR;
    r.error_code = code;
    return 1;
  endfunction

  function automatic logic chunk_open(output out_item_t r);
    logic [31:0] vc;
    r = '0;
    cnt = 0;
    if (tagsh == TAG_FMT) begin
      if (clen < 16) return halt(r, ERR_FMT);
      vbits = 0; cbsize = 0; subfmt = 0;
      phase = P_FMT;
      return 0;
    end
    if (tagsh == TAG_DATA) begin
      if (!have_fmt) return halt(r, ERR_ORDER);
      if (!layout_good()) return halt(r, ERR_LAYOUT);
      acc = 0;
      bidx = 0;
      if (clen == 0) begin
        have_data = 1;
        phase = P_DONE;
      end else phase = P_DATA;
      vc = clamp_vb();
      r.kind = KIND_FORMAT;
      r.sample_rate = rate;
      r.sample_bits = bits[6:0];
      r.valid_bits = vc[5:0];
      r.is_float = float_fmt();
      return 1;
    end
    if (clen == 0) end_chunk();
    else phase = P_SKIP;
    return 0;
  endfunction

  function automatic logic fmt_field(output out_item_t r, input logic [7:0] b);
    logic [31:0] off;
    logic [15:0] ext;
    logic ok;
    r = '0;
    off = cnt;
    if (off < 2) ftag[off[0]*8 +: 8] = b;
    else if (off < 4) nch[off[0]*8 +: 8] = b;
    else if (off < 8) rate[off[1:0]*8 +: 8] = b;
    else if (off == 14 || off == 15) bits[off[0]*8 +: 8] = b;
    else if (off == 16 || off == 17) cbsize[off[0]*8 +: 8] = b;
    else if (off >= 18 && ftag == FMT_EXT && cbsize >= 22 && clen >= 40) begin
      if (off < 20) vbits[off[0]*8 +: 8] = b;
      else if (off >= 24 && off < 28) subfmt[off[1:0]*8 +: 8] = b;
    end
    if (off + 32'd1 == clen) begin
      ext = vbits;
      vbits = bits;
      if (ftag == FMT_PCM || ftag == FMT_FLOAT) ok = 1;
      else if (ftag != FMT_EXT) ok = 0;
      else begin
        if (ext != 0) vbits = ext;
        ok = subfmt == 32'd1 || subfmt == 32'd3;
      end
      if (!ok) return halt(r, ERR_TAG);
      have_fmt = 1;
      end_chunk();
      return 0;
    end
    cnt = off + 1;
    return 0;
  endfunction

  function automatic logic data_field(output out_item_t r, input logic [7:0] b);
    logic got;
    r = '0;
    got = 0;
    acc |= 64'(b) << (8 * bidx);
    if (32'(bidx) + 1 >= 32'(bits / 8)) begin
      r.kind = KIND_SAMPLE;
      r.sample_value = convert();
      got = 1;
      acc = 0;
      bidx = 0;
    end else bidx = bidx + 1;
    if (cnt + 32'd1 == clen) begin
      have_data = 1;
      phase = P_DONE;
    end else cnt = cnt + 1;
    return got;
  endfunction

  function automatic logic header_field(output out_item_t r, input logic [7:0] b);
    phase_t ph;
    r = '0;
    ph = phase;
    if (ph == P_CSIZE || ph == P_RSIZE) clen = {b, clen[31:8]};
    else tagsh = {b, tagsh[31:8]};
    if (cnt < 3) begin
      cnt = cnt + 1;
      return 0;
    end
    cnt = 0;
    case (ph)
      P_RIFF: begin
        if (tagsh != TAG_RIFF) return halt(r, ERR_HEADER);
        phase = P_RSIZE;
      end
      P_RSIZE: phase = P_WAVE;
      P_WAVE: begin
        if (tagsh != TAG_WAVE) return halt(r, ERR_HEADER);
        phase = P_CTAG;
      end
      P_CTAG: phase = P_CSIZE;
      default: return chunk_open(r);
    endcase
    return 0;
  endfunction

  function automatic logic stream_end(output out_item_t r);
    r = '0;
    case (phase)
      P_RIFF, P_RSIZE, P_WAVE: return halt(r, ERR_HEADER);
      P_FMT: return halt(r, ERR_FMT);
      P_DONE: begin
        if (bidx != 0) return halt(r, ERR_PARTIAL);
        phase = P_HALT;
        r.kind = KIND_FINISH;
        return 1;
      end
      P_HALT: return 0;
      default: return halt(r, ERR_MISSING);
    endcase
  endfunction

  function automatic logic predict(input in_item_t it, output out_item_t r);
    r = '0;
    if (it.mode == MODE_RESTART) begin
      clear_parser();
      return 0;
    end
    if (it.mode == MODE_END) return stream_end(r);
    if (it.mode != MODE_BYTE) return 0;
    case (phase)
      P_RIFF, P_RSIZE, P_WAVE, P_CTAG, P_CSIZE: return header_field(r, it.byte_value);
      P_FMT: return fmt_field(r, it.byte_value);
      P_SKIP: begin
        if (cnt + 32'd1 == clen) end_chunk();
        else cnt = cnt + 1;
      end
      P_PAD: begin
        cnt = 0;
        phase = P_CTAG;
      end
      P_DATA: return data_field(r, it.byte_value);
      default: ;
    endcase
    return 0;
  endfunction

  initial begin
    fails = 0; pending = 0;
    n_samples = 0; n_formats = 0; n_errors = 0; n_finish = 0;
    clear_parser();
  end

  always @(posedge clk) begin
    out_item_t r, e;
    if (rst) begin
      clear_parser();
      exp_q.delete();
    end else begin
      if (push && !full && predict(request, r)) exp_q.push_back(r);
      if (pop && !empty) begin
        if (exp_q.size() == 0) begin
          if (fails < 10) $display("unexpected result kind=%0d at %0t", result.kind, $realtime);
          fails = fails + 1;
        end else begin
          e = exp_q.pop_front();
          case (e.kind)
            KIND_SAMPLE: n_samples = n_samples + 1;
            KIND_FORMAT: n_formats = n_formats + 1;
            KIND_ERROR: n_errors = n_errors + 1;
            default: n_finish = n_finish + 1;
          endcase
          if (result.kind !== e.kind || result.sample_value !== e.sample_value ||
              result.sample_rate !== e.sample_rate || result.sample_bits !== e.sample_bits ||
              result.valid_bits !== e.valid_bits || result.is_float !== e.is_float ||
              result.error_code !== e.error_code) begin
            if (fails < 10) begin
              $display("mismatch at %0t: exp k=%0d s=%h r=%0d b=%0d v=%0d f=%0d e=%0d",
                       $realtime, e.kind, e.sample_value, e.sample_rate, e.sample_bits,
                       e.valid_bits, e.is_float, e.error_code);
              $display("  got k=%0d s=%h r=%0d b=%0d v=%0d f=%0d e=%0d",
                       result.kind, result.sample_value, result.sample_rate,
                       result.sample_bits, result.valid_bits, result.is_float,
                       result.error_code);
            end
            fails = fails + 1;
          end
        end
      end
    end
    pending <= exp_q.size();
  end
endmodule

// ===== tb/tb.sv =====
// tb: drives WAV byte streams into wav_stream_decoder and gives the verdict.
// Depends on wsd_pkg, wav_stream_decoder and wsd_scoreboard.
`timescale 1ns / 1ps
module tb;
  import wsd_pkg::*;

  logic clk, rst, push, full, empty, pop, calm;
  in_item_t request;
  out_item_t result;
  int fails, pending, n_samples, n_formats, n_errors, n_finish;
  int sent, files;
  logic [7:0] file_q[$];

  wav_stream_decoder u_top (
    .clk(clk), .rst(rst), .push(push), .full(full), .request(request),
    .empty(empty), .pop(pop), .result(result)
  );

  wsd_scoreboard u_chk (
    .clk(clk), .rst(rst), .push(push), .full(full), .request(request), .empty(empty),
    .pop(pop), .result(result), .fails(fails), .pending(pending), .n_samples(n_samples),
    .n_formats(n_formats), .n_errors(n_errors), .n_finish(n_finish)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  always @(posedge clk) pop <= calm || ($urandom_range(99) >= 11);

  task automatic send(logic [1:0] m, logic [7:0] b);
    logic ok;
    if (!calm && $urandom_range(99) < 11) begin
      push <= 0;
      @(posedge clk);
    end
    request <= '{mode: m, byte_value: b};
    push <= 1;
    do begin
      @(negedge clk);
      ok = !full;
      @(posedge clk);
    end while (!ok);
    sent = sent + 1;
    calm = sent >= 700 && sent < 1000;
  endtask

  task automatic drain();
    push <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic add_w(logic [63:0] v, int n);
    for (int i = 0; i < n; i++) file_q.push_back(v[i*8 +: 8]);
  endtask

  task automatic add_s(string s);
    for (int i = 0; i < s.len(); i++) file_q.push_back(s[i]);
  endtask

  task automatic add_junk();
    int n;
    n = $urandom_range(0, 9);
    if ($urandom_range(1)) add_s("LIST");
    else add_w($urandom, 4);
    add_w(n, 4);
    repeat (n + (n % 2)) add_w($urandom, 1);
  endtask

  function automatic logic [63:0] f32_word();
    logic [31:0] w;
    w = $urandom;
    case ($urandom_range(9))
      0: w[30:0] = 0;
      1: w[30:0] = {8'hFF, 23'd0};
      2: w[30:23] = 8'hFF;
      3: w[30:23] = 0;
      4: w[30:23] = $urandom_range(160, 254);
      default: w[30:23] = $urandom_range(100, 158);
    endcase
    return {32'd0, w};
  endfunction

  function automatic logic [63:0] f64_word();
    logic [63:0] w;
    w = {$urandom, $urandom};
    case ($urandom_range(9))
      0: w[62:0] = 0;
      1: w[62:0] = {11'h7FF, 52'd0};
      2: w[62:52] = 11'h7FF;
      3: w[62:52] = 0;
      4: w[62:52] = $urandom_range(1060, 2046);
      default: w[62:52] = $urandom_range(990, 1054);
    endcase
    return w;
  endfunction

  task automatic build_file();
    logic [15:0] tag, bits, ch, cbs, vb;
    logic [31:0] sub, rate;
    logic [7:0] body[$];
    int r, flen, bps, ns, dlen, n;
    logic flt;
    file_q.delete();
    add_s($urandom_range(99) < 4 ? "RIFX" : "RIFF");
    add_w($urandom, 4);
    add_s($urandom_range(99) < 4 ? "WAVX" : "WAVE");
    if ($urandom_range(99) < 5) begin
      add_s("data");
      add_w(4, 4);
    end
    if ($urandom_range(99) < 30) add_junk();
    if ($urandom_range(99) < 5) begin
      add_s("fmt ");
      add_w($urandom_range(15), 4);
    end
    r = $urandom_range(99);
    sub = 0;
    if (r < 40) begin
      tag = FMT_PCM;
      bits = 8 * $urandom_range(1, 4);
    end else if (r < 65) begin
      tag = FMT_FLOAT;
      bits = $urandom_range(1) ? 16'd32 : 16'd64;
    end else if (r < 90) begin
      tag = FMT_EXT;
      sub = $urandom_range(99) < 10 ? $urandom_range(0, 5) : ($urandom_range(1) ? 1 : 3);
      bits = sub == 3 ? ($urandom_range(1) ? 16'd32 : 16'd64) : 8 * $urandom_range(1, 4);
    end else begin
      tag = $urandom;
      bits = 16;
    end
    if ($urandom_range(99) < 8) bits = $urandom_range(0, 80);
    ch = $urandom_range(99) < 92 ? 16'd1 : 16'($urandom_range(0, 3));
    rate = $urandom_range(99) < 95 ? ($urandom | 32'd1) : 32'd0;
    cbs = 0;
    if (tag == FMT_EXT) begin
      flen = $urandom_range(99) < 85 ? 40 : $urandom_range(18, 44);
      cbs = $urandom_range(99) < 85 ? 16'd22 : 16'($urandom_range(0, 30));
    end else flen = $urandom_range(99) < 70 ? 16 : $urandom_range(17, 21);
    vb = $urandom_range(99) < 85 ? 16'($urandom_range(1, bits > 0 ? bits : 1))
                                 : 16'($urandom_range(0, 40));
    body.delete();
    for (int i = 0; i < 48; i++) body.push_back($urandom);
    {body[1], body[0]} = tag;
    {body[3], body[2]} = ch;
    {body[7], body[6], body[5], body[4]} = rate;
    {body[15], body[14]} = bits;
    {body[17], body[16]} = cbs;
    {body[19], body[18]} = vb;
    {body[27], body[26], body[25], body[24]} = sub;
    add_s("fmt ");
    add_w(flen, 4);
    for (int i = 0; i < flen; i++) file_q.push_back(body[i]);
    if (flen % 2) add_w($urandom, 1);
    if ($urandom_range(99) < 20) add_junk();
    flt = tag == FMT_FLOAT || (tag == FMT_EXT && sub == 3);
    bps = (bits / 8 >= 1 && bits / 8 <= 8) ? bits / 8 : 2;
    ns = $urandom_range(99) < 10 ? $urandom_range(20, 40) : $urandom_range(0, 10);
    dlen = ns * bps;
    if (bps > 1 && $urandom_range(99) < 10) dlen += $urandom_range(1, bps - 1);
    add_s("data");
    add_w(dlen, 4);
    n = 0;
    while (n < dlen) begin
      logic [63:0] w;
      if (flt && bits == 32) w = f32_word();
      else if (flt && bits == 64) w = f64_word();
      else w = {$urandom, $urandom};
      for (int i = 0; i < bps && n < dlen; i++) begin
        file_q.push_back(w[i*8 +: 8]);
        n++;
      end
    end
    if ($urandom_range(99) < 20) repeat ($urandom_range(1, 6)) add_w($urandom, 1);
    if ($urandom_range(99) < 8)
      while (file_q.size() > 0 && $urandom_range(99) < 97) void'(file_q.pop_back());
  endtask

  initial begin
    string hdr;
    rst = 1; push = 0; pop = 0; calm = 0; request = '0;
    sent = 0; files = 0;
    repeat (10) @(posedge clk);
    rst <= 0;
    hdr = "RIFX";
    for (int i = 0; i < hdr.len(); i++) send(MODE_BYTE, hdr[i]);
    send(MODE_BYTE, 8'hFF);
    send(MODE_END, 8'h00);
    send(MODE_RESTART, 8'h00);
    send(MODE_BYTE, "R");
    send(MODE_END, 8'h00);
    send(MODE_RESTART, 8'h00);
    send(MODE_NONE, 8'hA5);
    hdr = "RIFF";
    for (int i = 0; i < hdr.len(); i++) send(MODE_BYTE, hdr[i]);
    repeat (4) send(MODE_BYTE, 8'h00);
    hdr = "WAVE";
    for (int i = 0; i < hdr.len(); i++) send(MODE_BYTE, hdr[i]);
    send(MODE_END, 8'h00);
    while (sent < 1950) begin
      build_file();
      send(MODE_RESTART, $urandom);
      foreach (file_q[i]) begin
        if ($urandom_range(199) == 0) send(MODE_NONE, $urandom);
        send(MODE_BYTE, file_q[i]);
      end
      if ($urandom_range(99) < 90) send(MODE_END, $urandom);
      if ($urandom_range(99) < 10) send($urandom_range(1) ? MODE_END : MODE_BYTE, $urandom);
      files++;
      if (files == 4) drain();
    end
    drain();
    repeat (20) @(posedge clk);
    $display("Ran %0d transfers in %0d files: %0d samples, %0d format reports,",
             sent, files, n_samples, n_formats);
    $display("%0d errors and %0d clean finishes checked.", n_errors, n_finish);
    if (fails == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
sv/wsd_pkg.sv
sv/wsd_fifo.sv
sv/wsd_front.sv
sv/wsd_back.sv
sv/wav_stream_decoder.sv
sv/wsd_checker.sv
tb/wsd_checker.sv
tb/tb.sv
